/* design/frustum_sphere_cull_test_unit_defines.svh */
// ----------------------------------------------------------------------------
// frustum sphere cull test unit - assertion macros
// shared property forms for the checker of the cull test unit
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_SPHERE_CULL_TEST_UNIT_DEFINES_SVH
`define FRUSTUM_SPHERE_CULL_TEST_UNIT_DEFINES_SVH

// same-cycle implication, off while reset is high
`define FSC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fsc check failed");

// next-cycle implication, off while reset is high
`define FSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fsc check failed");

`endif

/* design/fsc_pkg.sv */
// ----------------------------------------------------------------------------
// fsc_pkg - frustum sphere cull test package
// widths, types, plane layout and register codes of the cull test unit
// ----------------------------------------------------------------------------
`default_nettype none

package fsc_pkg;

   // centre format, signed, FRAC_BITS fraction bits
   localparam int COORD_WIDTH = 20;
   localparam int FRAC_BITS   = 12;

   // matrix lanes are signed Q4.12
   localparam int LANE_W      = 16;
   localparam int LANE_FRAC   = 12;
   localparam int LANE_COUNT  = 4;
   localparam int ROW_COUNT   = 4;
   localparam int AXIS_COUNT  = 3;
   localparam int PLANE_COUNT = 6;

   localparam int NORM_W   = LANE_W + 1;
   localparam int RADIUS_W = COORD_WIDTH - 1;
   localparam int PROD_W   = NORM_W + COORD_WIDTH;
   localparam int DIST_W   = NORM_W + FRAC_BITS;
   localparam int RSC_W    = RADIUS_W + LANE_FRAC + 1;

   localparam int WIDE_PD  = (PROD_W > DIST_W) ? PROD_W : DIST_W;
   localparam int WIDEST   = (WIDE_PD > RSC_W) ? WIDE_PD : RSC_W;
   // four terms in the plane value, plus headroom
   localparam int VALUE_W  = WIDEST + 3;
   localparam int CMP_W    = VALUE_W + 1;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = LANE_W * LANE_COUNT;
   localparam int COL_W       = 2;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic        [RADIUS_W-1:0]    radius_type;
   typedef logic signed [LANE_W-1:0]      lane_type;
   typedef logic signed [NORM_W-1:0]      norm_type;
   typedef logic signed [PROD_W-1:0]      prod_type;
   typedef logic signed [DIST_W-1:0]      dist_type;
   typedef logic signed [RSC_W-1:0]       rsc_type;
   typedef logic signed [VALUE_W-1:0]     value_type;
   typedef logic signed [CMP_W-1:0]       cmp_type;
   typedef logic        [CSR_DATA_W-1:0]  row_type;
   typedef logic        [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic        [COL_W-1:0]       col_type;

   // register indexes
   localparam csr_index_type CSR_MATRIX_ROW0 = 2'd0;
   localparam csr_index_type CSR_MATRIX_ROW1 = 2'd1;
   localparam csr_index_type CSR_MATRIX_ROW2 = 2'd2;
   localparam csr_index_type CSR_MATRIX_ROW3 = 2'd3;

   localparam row_type MATRIX_RESET [ROW_COUNT] = '{
      64'h0000_0000_0000_1000,
      64'h0000_0000_1000_0000,
      64'h0000_1000_0000_0000,
      64'h1000_0000_0000_0000
   };

   // row 3 of the matrix holds the distance terms, column 3 is the w column
   localparam int      DIST_ROW = 3;
   localparam col_type W_COL    = 2'd3;

   // right, left, down, up, far, near
   localparam col_type PLANE_COL [PLANE_COUNT] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
   localparam logic    PLANE_ADD [PLANE_COUNT] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

endpackage

`default_nettype wire

/* design/frustum_sphere_cull_test_unit.sv */
// ----------------------------------------------------------------------------
// frustum_sphere_cull_test_unit - point and sphere test against six clip planes
// a req transfer passes each stage register below to rsp valid; one item per cycle unless rsp_stall holds
// stages: capture, 18 parallel 17x20 multiplies, pair sums, plane value, compares
// sync reset clears valid bits and loads the identity matrix; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module frustum_sphere_cull_test_unit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire fsc_pkg::coord_type    req_centre_x,
   input  wire fsc_pkg::coord_type    req_centre_y,
   input  wire fsc_pkg::coord_type    req_centre_z,
   input  wire fsc_pkg::radius_type   req_sphere_radius,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_point_inside,
   output logic                       rsp_sphere_touches,
   output logic                       rsp_sphere_contained,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire fsc_pkg::csr_index_type csr_index,
   input  wire fsc_pkg::row_type      csr_wdata
);

   import fsc_pkg::*;

   // configuration and plane coefficients
   row_type   matrix_ff [ROW_COUNT];
   norm_type  normal_in [PLANE_COUNT][AXIS_COUNT];
   norm_type  normal_ff [PLANE_COUNT][AXIS_COUNT];
   norm_type  dnorm_in  [PLANE_COUNT];
   dist_type  dist_ff   [PLANE_COUNT];

   // pipeline enables
   logic en1, en2, en3, en4, en5;

   // stage 1: captured item
   logic       s1_valid_ff;
   coord_type  s1_centre_ff [AXIS_COUNT];
   radius_type s1_radius_ff;

   // stage 2: products
   logic       s2_valid_ff;
   prod_type   prod_in [PLANE_COUNT][AXIS_COUNT];
   prod_type   s2_prod_ff [PLANE_COUNT][AXIS_COUNT];
   rsc_type    rsc_in;
   rsc_type    s2_rsc_ff;

   // stage 3: pair sums
   logic       s3_valid_ff;
   value_type  sum_a_in [PLANE_COUNT];
   value_type  sum_b_in [PLANE_COUNT];
   value_type  s3_sum_a_ff [PLANE_COUNT];
   value_type  s3_sum_b_ff [PLANE_COUNT];
   rsc_type    s3_rsc_ff;

   // stage 4: plane values
   logic       s4_valid_ff;
   value_type  value_in [PLANE_COUNT];
   value_type  s4_value_ff [PLANE_COUNT];
   rsc_type    s4_rsc_ff;

   // stage 5: output register
   logic       rsp_valid_ff;
   logic       inside_ff, touches_ff, contained_ff;
   logic       inside_in, touches_in, contained_in;
   cmp_type    vext [PLANE_COUNT];
   cmp_type    vsum [PLANE_COUNT];
   cmp_type    rext;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ROW_COUNT; k++) begin
            matrix_ff[k] <= MATRIX_RESET[k];
         end
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MATRIX_ROW0: matrix_ff[0] <= csr_wdata;
            CSR_MATRIX_ROW1: matrix_ff[1] <= csr_wdata;
            CSR_MATRIX_ROW2: matrix_ff[2] <= csr_wdata;
            CSR_MATRIX_ROW3: matrix_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // plane j row k: w column plus or minus column PLANE_COL[j]
   always_comb begin
      for (int j = 0; j < PLANE_COUNT; j++) begin
         for (int k = 0; k < AXIS_COUNT; k++) begin
            if (PLANE_ADD[j]) begin
               normal_in[j][k] =
                  NORM_W'(lane_type'(matrix_ff[k][LANE_W*W_COL +: LANE_W])) +
                  NORM_W'(lane_type'(matrix_ff[k][LANE_W*PLANE_COL[j] +: LANE_W]));
            end else begin
               normal_in[j][k] =
                  NORM_W'(lane_type'(matrix_ff[k][LANE_W*W_COL +: LANE_W])) -
                  NORM_W'(lane_type'(matrix_ff[k][LANE_W*PLANE_COL[j] +: LANE_W]));
            end
         end
         if (PLANE_ADD[j]) begin
            dnorm_in[j] =
               NORM_W'(lane_type'(matrix_ff[DIST_ROW][LANE_W*W_COL +: LANE_W])) +
               NORM_W'(lane_type'(matrix_ff[DIST_ROW][LANE_W*PLANE_COL[j] +: LANE_W]));
         end else begin
            dnorm_in[j] =
               NORM_W'(lane_type'(matrix_ff[DIST_ROW][LANE_W*W_COL +: LANE_W])) -
               NORM_W'(lane_type'(matrix_ff[DIST_ROW][LANE_W*PLANE_COL[j] +: LANE_W]));
         end
      end
   end

   // coefficients are registered from the matrix and follow it in the next cycle
   always_ff @(posedge clock) begin
      for (int j = 0; j < PLANE_COUNT; j++) begin
         normal_ff[j] <= normal_in[j];
         // distance shifted by the centre's fraction bits to the products' scale
         dist_ff[j]   <= {dnorm_in[j], {FRAC_BITS{1'b0}}};
      end
   end

   // ---------------------------------------------------------------- flow
   assign en5       = !rsp_valid_ff || !rsp_stall;
   assign en4       = !s4_valid_ff || en5;
   assign en3       = !s3_valid_ff || en4;
   assign en2       = !s2_valid_ff || en3;
   assign en1       = !s1_valid_ff || en2;
   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) begin
            s1_valid_ff <= req_valid;
         end
         if (en2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (en3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (en4) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (en5) begin
            rsp_valid_ff <= s4_valid_ff;
         end
      end
   end

   // ---------------------------------------------------------------- stage 1
   always_ff @(posedge clock) begin
      if (en1) begin
         s1_centre_ff[0] <= req_centre_x;
         s1_centre_ff[1] <= req_centre_y;
         s1_centre_ff[2] <= req_centre_z;
         s1_radius_ff    <= req_sphere_radius;
      end
   end

   // ---------------------------------------------------------------- stage 2
   always_comb begin
      for (int j = 0; j < PLANE_COUNT; j++) begin
         for (int k = 0; k < AXIS_COUNT; k++) begin
            prod_in[j][k] = PROD_W'(normal_ff[j][k]) * PROD_W'(s1_centre_ff[k]);
         end
      end
   end

   // radius aligned to the plane value's fraction bits
   assign rsc_in = rsc_type'({s1_radius_ff, {LANE_FRAC{1'b0}}});

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_prod_ff <= prod_in;
         s2_rsc_ff  <= rsc_in;
      end
   end

   // ---------------------------------------------------------------- stage 3
   always_comb begin
      for (int j = 0; j < PLANE_COUNT; j++) begin
         sum_a_in[j] = VALUE_W'(s2_prod_ff[j][0]) + VALUE_W'(s2_prod_ff[j][1]);
         sum_b_in[j] = VALUE_W'(s2_prod_ff[j][2]) + VALUE_W'(dist_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_sum_a_ff <= sum_a_in;
         s3_sum_b_ff <= sum_b_in;
         s3_rsc_ff   <= s2_rsc_ff;
      end
   end

   // ---------------------------------------------------------------- stage 4
   always_comb begin
      for (int j = 0; j < PLANE_COUNT; j++) begin
         value_in[j] = s3_sum_a_ff[j] + s3_sum_b_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_value_ff <= value_in;
         s4_rsc_ff   <= s3_rsc_ff;
      end
   end

   // ---------------------------------------------------------------- stage 5
   assign rext = CMP_W'(s4_rsc_ff);

   always_comb begin
      inside_in    = 1'b1;
      touches_in   = 1'b1;
      contained_in = 1'b1;
      for (int j = 0; j < PLANE_COUNT; j++) begin
         vext[j] = CMP_W'(s4_value_ff[j]);
         vsum[j] = vext[j] + rext;
         // strictly positive: sign clear and not zero
         if (vext[j][CMP_W-1] || (vext[j] == '0)) begin
            inside_in = 1'b0;
         end
         if (vsum[j][CMP_W-1] || (vsum[j] == '0)) begin
            touches_in = 1'b0;
         end
         if (vext[j] < rext) begin
            contained_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         inside_ff    <= inside_in;
         touches_ff   <= touches_in;
         contained_ff <= contained_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_point_inside     = inside_ff;
   assign rsp_sphere_touches   = touches_ff;
   assign rsp_sphere_contained = contained_ff;

endmodule

`default_nettype wire

/* design/fsc_checker.sv */
// ----------------------------------------------------------------------------
// fsc_checker - port checker for the frustum sphere cull test unit
// watches the response channel and the register port over time
// ----------------------------------------------------------------------------
`default_nettype none

`include "frustum_sphere_cull_test_unit_defines.svh"

module fsc_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire logic                   rsp_point_inside,
   input wire logic                   rsp_sphere_touches,
   input wire logic                   rsp_sphere_contained,
   input wire logic                   csr_valid,
   input wire logic                   csr_ready
);

   // a stalled response stays up
   `FSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // a stalled response keeps its flags
   `FSC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall,
      $stable(rsp_point_inside) && $stable(rsp_sphere_touches) &&
      $stable(rsp_sphere_contained))

   // a point strictly inside every plane always touches for any radius
   `FSC_ASSERT_NOW(a_inside_touches, clock, reset, rsp_valid && rsp_point_inside,
      rsp_sphere_touches)

   // the register port never pushes back
   `FSC_ASSERT_NOW(a_csr_ready, clock, reset, csr_valid, csr_ready)

endmodule

bind frustum_sphere_cull_test_unit fsc_checker u_fsc_checker (.*);

`default_nettype wire
